FILE: rtl/core/csm_pkg.sv
// Shared types, sizes and helpers for the case-insensitive substring matcher.
// No dependencies; every other file in rtl/core refers to this package.

package csm_pkg;

    localparam int MAX_PATTERN = 128;
    localparam int MAX_TEXT    = 256;

    localparam int PLEN_W = $clog2(MAX_PATTERN + 1);
    localparam int TPOS_W = $clog2(MAX_TEXT + 1);
    localparam int POS_W  = 8;
    localparam int SUM_W  = (TPOS_W > PLEN_W) ?
                            ((TPOS_W > POS_W) ? TPOS_W : POS_W) :
                            ((PLEN_W > POS_W) ? PLEN_W : POS_W);

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_APPEND = 2'd1,
        CMD_TEXT   = 2'd2
    } cmd_t;

    // Broadcast to every cell of the row
    typedef struct packed {
        logic       clear_pat;   // drop the stored pattern
        logic       append;      // load data into the first free cell
        logic       reset_text;  // drop partial matches
        logic       step;        // advance partial matches by one text byte
        logic [7:0] data;        // folded byte
    } cell_ctl_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             truncated;
    } result_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/case_insensitive_substring_match.sv
// Top level of the case-insensitive substring matcher: a row of csm_cell
// cells, text bookkeeping and the csm_out_skid result buffer. Uses csm_pkg.
//
// Usage
//   Command channel (cmd_valid / cmd_stall): one word per accepted edge with
//   command, data_byte and text_end. CMD_CLEAR empties the pattern,
//   CMD_APPEND adds a byte (ignored once MAX_PATTERN bytes are held),
//   CMD_TEXT feeds one text byte; text_end on a text byte closes the text.
//   Clear and append also abandon a text in progress. Code 3 is ignored.
//   Result channel (res_valid / res_stall): one word per closed text with
//   found, match_position (leftmost start, 0 if none) and truncated.
//   Throughput: one command word per cycle while cmd_stall is low, text bytes
//   included. Each cell compares its pattern byte against the broadcast text
//   byte and hands its partial-match bit to the next cell, so the whole row
//   advances per cycle. Results: the word for a closed text is written into
//   csm_out_skid as the final text byte is accepted, behind any held words.
//   Stall: results queue in a two-word buffer; cmd_stall rises only when both
//   words are held, and falls as soon as the receiver takes one.
//   Reset: pattern length, partial matches and text state clear at once;
//   stored pattern bytes are undefined until appended again. No result is
//   pending after reset.

module case_insensitive_substring_match (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_valid,
    output logic                      cmd_stall,
    input  logic [1:0]                command,
    input  logic [7:0]                data_byte,
    input  logic                      text_end,
    output logic                      res_valid,
    input  logic                      res_stall,
    output logic                      found,
    output logic [csm_pkg::POS_W-1:0] match_position,
    output logic                      truncated
);

    localparam int NC = csm_pkg::MAX_PATTERN;

    logic                        accept;
    csm_pkg::cmd_t               cmd;
    logic                        is_clear;
    logic                        is_append;
    logic                        is_text;
    logic                        room;
    logic                        step;
    csm_pkg::cell_ctl_t          ctl;

    logic [NC-1:0]               en;
    logic [NC-1:0]               hit;
    logic [NC-1:0]               tail_hit;
    logic                        any_tail;

    logic [csm_pkg::PLEN_W-1:0]  plen_reg;
    logic [csm_pkg::PLEN_W-1:0]  plen_next;
    logic [csm_pkg::TPOS_W-1:0]  tpos_reg;
    logic [csm_pkg::TPOS_W-1:0]  tpos_next;
    logic                        seen_reg;
    logic                        seen_next;
    logic [csm_pkg::POS_W-1:0]   start_reg;
    logic [csm_pkg::POS_W-1:0]   start_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic [csm_pkg::SUM_W-1:0]   start_sum;

    logic                        seen_now;
    logic [csm_pkg::POS_W-1:0]   start_now;
    logic                        ovf_now;
    logic                        res_push;
    csm_pkg::result_t            res_word;
    csm_pkg::result_t            res_out;

    assign accept = cmd_valid && !cmd_stall;
    assign cmd    = csm_pkg::cmd_t'(command);

    always_comb
    begin
        is_clear  = 1'b0;
        is_append = 1'b0;
        is_text   = 1'b0;
        case (cmd)
            csm_pkg::CMD_CLEAR:  is_clear  = accept;
            csm_pkg::CMD_APPEND: is_append = accept;
            csm_pkg::CMD_TEXT:   is_text   = accept;
            default:             ;
        endcase
    end

    // bytes past MAX_TEXT take no part in matching
    assign room = (tpos_reg < csm_pkg::TPOS_W'(csm_pkg::MAX_TEXT));
    assign step = is_text && room;

    assign ctl.clear_pat  = is_clear;
    assign ctl.append     = is_append;
    assign ctl.reset_text = is_clear || is_append || (is_text && text_end);
    assign ctl.step       = step;
    assign ctl.data       = csm_pkg::fold_case(data_byte);

    // Cell row: enable and partial-match bits ripple from cell 0 upward
    genvar gi;
    generate
        for (gi = 0; gi < NC; gi++)
        begin : g_cell
            logic prev_en;
            logic prev_hit;
            logic next_en;
            if (gi == 0)
            begin : g_first
                assign prev_en  = 1'b1;
                assign prev_hit = 1'b1;
            end
            else
            begin : g_mid
                assign prev_en  = en[gi-1];
                assign prev_hit = hit[gi-1];
            end
            if (gi == NC - 1)
            begin : g_last
                assign next_en = 1'b0;
            end
            else
            begin : g_notlast
                assign next_en = en[gi+1];
            end
            csm_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .prev_en  (prev_en),
                .prev_hit (prev_hit),
                .next_en  (next_en),
                .en       (en[gi]),
                .hit      (hit[gi]),
                .tail_hit (tail_hit[gi])
            );
        end
    endgenerate

    // Only the last occupied cell can report a full match
    assign any_tail = |tail_hit;

    assign start_sum = csm_pkg::SUM_W'(tpos_reg) + csm_pkg::SUM_W'(1)
                     - csm_pkg::SUM_W'(plen_reg);

    always_comb
    begin
        seen_now  = seen_reg;
        start_now = start_reg;
        ovf_now   = ovf_reg;
        if (step && !seen_reg && any_tail)
        begin
            seen_now  = 1'b1;
            start_now = start_sum[csm_pkg::POS_W-1:0];
        end
        if (is_text && !room)
        begin
            ovf_now = 1'b1;
        end
    end

    always_comb
    begin
        plen_next  = plen_reg;
        tpos_next  = tpos_reg;
        seen_next  = seen_now;
        start_next = start_now;
        ovf_next   = ovf_now;
        if (step)
        begin
            tpos_next = tpos_reg + csm_pkg::TPOS_W'(1);
        end
        if (is_clear)
        begin
            plen_next = '0;
        end
        else if (is_append && plen_reg < csm_pkg::PLEN_W'(csm_pkg::MAX_PATTERN))
        begin
            plen_next = plen_reg + csm_pkg::PLEN_W'(1);
        end
        // drop the text state on pattern change or end of text
        if (ctl.reset_text)
        begin
            tpos_next  = '0;
            seen_next  = 1'b0;
            start_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plen_reg  <= '0;
            tpos_reg  <= '0;
            seen_reg  <= 1'b0;
            start_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            plen_reg  <= plen_next;
            tpos_reg  <= tpos_next;
            seen_reg  <= seen_next;
            start_reg <= start_next;
            ovf_reg   <= ovf_next;
        end
    end

    // Result word; an empty pattern matches at position zero
    assign res_push = is_text && text_end;

    always_comb
    begin
        res_word.truncated = ovf_now;
        if (plen_reg == '0)
        begin
            res_word.found          = 1'b1;
            res_word.match_position = '0;
        end
        else
        begin
            res_word.found          = seen_now;
            res_word.match_position = seen_now ? start_now : '0;
        end
    end

    csm_out_skid u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .push_res (res_word),
        .valid    (res_valid),
        .stall    (res_stall),
        .res      (res_out),
        .full     (cmd_stall)
    );

    assign found          = res_out.found;
    assign match_position = res_out.match_position;
    assign truncated      = res_out.truncated;

endmodule

FILE: rtl/core/csm_cell.sv
// One cell of the matcher row: a pattern byte, its valid flag and one
// partial-match bit. Depends on csm_pkg.

module csm_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  csm_pkg::cell_ctl_t ctl,
    input  logic               prev_en,
    input  logic               prev_hit,
    input  logic               next_en,
    output logic               en,
    output logic               hit,
    output logic               tail_hit
);

    logic [7:0] byte_reg;
    logic       en_reg;
    logic       en_next;
    logic       pm_reg;
    logic       pm_next;
    logic       load;
    logic       cmp;

    // first free cell takes the appended byte
    assign load = ctl.append && prev_en && !en_reg;
    assign cmp  = prev_hit && en_reg && (byte_reg == ctl.data);

    always_comb
    begin
        en_next = en_reg;
        if (ctl.clear_pat)
        begin
            en_next = 1'b0;
        end
        else if (load)
        begin
            en_next = 1'b1;
        end
    end

    always_comb
    begin
        pm_next = pm_reg;
        if (ctl.reset_text)
        begin
            pm_next = 1'b0;
        end
        else if (ctl.step)
        begin
            pm_next = cmp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            en_reg <= 1'b0;
            pm_reg <= 1'b0;
        end
        else
        begin
            en_reg <= en_next;
            pm_reg <= pm_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= ctl.data;
        end
    end

    assign en       = en_reg;
    assign hit      = pm_reg;
    assign tail_hit = cmp && !next_en;

endmodule

FILE: rtl/core/csm_out_skid.sv
// Two-word result buffer: output register plus one skid word.
// Depends on csm_pkg.

module csm_out_skid (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  csm_pkg::result_t   push_res,
    output logic               valid,
    input  logic               stall,
    output csm_pkg::result_t   res,
    output logic               full
);

    csm_pkg::result_t head_reg;
    csm_pkg::result_t head_next;
    csm_pkg::result_t skid_reg;
    csm_pkg::result_t skid_next;
    logic             head_valid_reg;
    logic             head_valid_next;
    logic             skid_valid_reg;
    logic             skid_valid_next;
    logic             pop;

    assign pop = head_valid_reg && !stall;

    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                // advance skid word, refill skid with any new word
                head_next       = skid_reg;
                skid_valid_next = push;
                skid_next       = push_res;
            end
            else
            begin
                head_valid_next = push;
                head_next       = push_res;
            end
        end
        else if (!head_valid_reg)
        begin
            head_valid_next = push;
            head_next       = push_res;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign valid = head_valid_reg;
    assign res   = head_reg;
    assign full  = skid_valid_reg;

endmodule

FILE: rtl/core/csm_checker.sv
// Port-level checks for case_insensitive_substring_match, attached by bind.
// Depends on csm_pkg.

module csm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      cmd_valid,
    input logic                      cmd_stall,
    input logic [1:0]                command,
    input logic                      text_end,
    input logic                      res_valid,
    input logic                      res_stall,
    input logic                      found,
    input logic [csm_pkg::POS_W-1:0] match_position
);

    // a held result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result word dropped while stalled");

    // a new result follows an accepted final text byte
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_valid && !cmd_stall && text_end
                                   && command == csm_pkg::CMD_TEXT))
        else $error("result without a closed text");

    // no match reports position zero
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !found |-> match_position == '0)
        else $error("nonzero position without a match");

    // command side stalls only while results are waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> res_valid)
        else $error("command stall with no pending result");

endmodule

bind case_insensitive_substring_match csm_checker u_csm_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .command        (command),
    .text_end       (text_end),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .found          (found),
    .match_position (match_position)
);

FILE: tb/tb_top.sv
// Self-checking testbench for case_insensitive_substring_match: a queued
// command driver, a result monitor and a shift-and predictor. Uses csm_pkg.
`timescale 1ns / 100ps

module tb_top;

    // Code 3 is not part of cmd_t; the block must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int LONG_HOLD_AT     = 30;    // result index that starts the long hold
    localparam int LONG_HOLD_CYCLES = 1000;

    typedef struct {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       last;
        int         gap;    // idle cycles before this word is offered
        bit         drain;  // offer only once every result has come back
    } cmd_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    logic [1:0] command = csm_pkg::CMD_CLEAR;
    logic [7:0] data_byte = 8'h00;
    logic       text_end = 1'b0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic       found;
    logic [csm_pkg::POS_W-1:0] match_position;
    logic       truncated;

    cmd_word_t          pending_words[$];
    csm_pkg::result_t   expected_results[$];
    int                 mismatches = 0;

    // Predictor state
    logic [7:0]                      pat_mem [csm_pkg::MAX_PATTERN];
    int                              pat_len = 0;
    logic [csm_pkg::MAX_PATTERN-1:0] partials = '0;
    int                              text_pos = 0;
    bit                              hit_seen = 0;
    logic [7:0]                      hit_start = 8'h00;
    bit                              text_over = 0;

    // Generator state: the pattern as last built, raw case
    logic [7:0] gen_pat [256];
    int         gen_len = 0;
    int         words_queued = 0;
    int         texts_queued = 0;
    bit         tx_fast = 0;
    bit         rx_fast = 0;

    // Driver and monitor scratch
    bit take_cmd;
    int tx_cnt;
    bit take_res;
    int rx_cnt;
    int rx_hold = 0;
    int results_seen = 0;

    case_insensitive_substring_match uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .data_byte      (data_byte),
        .text_end       (text_end),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .found          (found),
        .match_position (match_position),
        .truncated      (truncated)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic drop_text();
        partials  = '0;
        text_pos  = 0;
        hit_seen  = 0;
        hit_start = 8'h00;
        text_over = 0;
    endtask

    // Advance the predicted matcher by one accepted command word; queue a
    // result when the word closes a text.
    task automatic track_matcher(input logic [1:0] cmd, input logic [7:0] d,
                                 input logic last);
        logic [csm_pkg::MAX_PATTERN-1:0] eq;
        logic [7:0]                      lc;
        csm_pkg::result_t                r;
        case (cmd)
            csm_pkg::CMD_CLEAR:
            begin
                pat_len = 0;
                drop_text();
            end
            csm_pkg::CMD_APPEND:
            begin
                if (pat_len < csm_pkg::MAX_PATTERN)
                begin
                    pat_mem[pat_len] = to_lower(d);
                    pat_len++;
                end
                drop_text();
            end
            csm_pkg::CMD_TEXT:
            begin
                if (text_pos < csm_pkg::MAX_TEXT)
                begin
                    lc = to_lower(d);
                    eq = '0;
                    for (int i = 0; i < pat_len; i++)
                    begin
                        eq[i] = (pat_mem[i] == lc);
                    end
                    partials = {partials[csm_pkg::MAX_PATTERN-2:0], 1'b1} & eq;
                    if (!hit_seen && pat_len > 0 && partials[pat_len-1])
                    begin
                        hit_seen  = 1;
                        hit_start = 8'((text_pos + 1 - pat_len) & 8'hFF);
                    end
                    text_pos++;
                end
                else
                begin
                    text_over = 1;
                end
                if (last)
                begin
                    r.found          = (pat_len == 0) ? 1'b1 : hit_seen;
                    r.match_position = (pat_len == 0 || !hit_seen) ? '0 : hit_start;
                    r.truncated      = text_over;
                    expected_results.push_back(r);
                    drop_text();
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Stimulus helpers: build words into pending_words
    // ---------------------------------------------------------------------

    task automatic queue_word(input logic [1:0] cmd, input logic [7:0] d,
                              input logic last, input bit drain = 0);
        cmd_word_t w;
        if (words_queued % 50 == 0)
        begin
            tx_fast = ($urandom_range(0, 3) == 0);
        end
        w.cmd   = cmd;
        w.data  = d;
        w.last  = last;
        w.gap   = tx_fast ? 0 : $urandom_range(0, 14);
        w.drain = drain;
        pending_words.push_back(w);
        words_queued++;
        if (cmd == csm_pkg::CMD_TEXT && last)
        begin
            texts_queued++;
        end
    endtask

    // Letters a-c and A-C, the ends of A-Z and a-z, their neighbors, or any code
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0, 1, 2: return 8'("a" + $urandom_range(0, 2));
            3, 4:    return 8'("A" + $urandom_range(0, 2));
            5:
            begin
                case ($urandom_range(0, 5))
                    0: return 8'h40;
                    1: return 8'h5B;
                    2: return 8'h60;
                    3: return 8'h7B;
                    4: return 8'h5A;
                    default: return 8'h7A;
                endcase
            end
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if ($urandom_range(0, 1) == 0)
        begin
            return c;
        end
        if (c >= "a" && c <= "z")
        begin
            return c - 8'h20;
        end
        if (c >= "A" && c <= "Z")
        begin
            return c + 8'h20;
        end
        return c;
    endfunction

    // Clear (or keep) the pattern and append len bytes
    task automatic build_pattern(input int len, input bit keep_old);
        logic [7:0] c;
        if (!keep_old)
        begin
            queue_word(csm_pkg::CMD_CLEAR, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
            gen_len = 0;
        end
        for (int i = 0; i < len; i++)
        begin
            c = pick_char();
            queue_word(csm_pkg::CMD_APPEND, c, 1'($urandom_range(0, 1)));
            if (gen_len < 256)
            begin
                gen_pat[gen_len] = c;
                gen_len++;
            end
        end
    endtask

    // Text of len bytes, rich in pattern pieces; close it only if closed is set
    task automatic build_text(input int len, input bit closed);
        int j;
        logic [7:0] c;
        j = 0;
        for (int i = 0; i < len; i++)
        begin
            if (gen_len > 0 && $urandom_range(0, 9) < 6)
            begin
                c = flip_case(gen_pat[j]);
                j = (j + 1) % ((gen_len < csm_pkg::MAX_PATTERN) ?
                               gen_len : csm_pkg::MAX_PATTERN);
            end
            else
            begin
                c = pick_char();
                if ($urandom_range(0, 3) == 0)
                begin
                    j = 0;
                end
            end
            queue_word(csm_pkg::CMD_TEXT, c, closed && (i == len - 1));
        end
    endtask

    task automatic build_noise(input int len);
        for (int i = 0; i < len; i++)
        begin
            queue_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        end
        // Whatever appends slipped in are no longer tracked by the generator
        gen_len = 0;
    endtask

    task automatic load_stimulus();
        int k;
        // Empty pattern: found at 0
        queue_word(csm_pkg::CMD_TEXT, "x", 1'b1);
        // Unused code and text_end on pattern commands: no effect
        queue_word(CMD_UNUSED, 8'hFF, 1'b1);
        queue_word(csm_pkg::CMD_APPEND, "A", 1'b1);
        queue_word(csm_pkg::CMD_APPEND, "b", 1'b0);
        queue_word(csm_pkg::CMD_TEXT, "x", 1'b0);
        queue_word(csm_pkg::CMD_TEXT, "a", 1'b0);
        queue_word(csm_pkg::CMD_TEXT, "B", 1'b1);
        // Extreme codes and the edges of the folded range
        queue_word(csm_pkg::CMD_CLEAR, 8'hFF, 1'b1);
        queue_word(csm_pkg::CMD_APPEND, 8'hFF, 1'b0);
        queue_word(csm_pkg::CMD_APPEND, 8'h00, 1'b0);
        queue_word(csm_pkg::CMD_APPEND, 8'h5A, 1'b0);
        queue_word(csm_pkg::CMD_APPEND, 8'h40, 1'b0);
        queue_word(csm_pkg::CMD_TEXT, 8'h00, 1'b0);
        queue_word(csm_pkg::CMD_TEXT, 8'hFF, 1'b0);
        queue_word(csm_pkg::CMD_TEXT, 8'h00, 1'b0);
        queue_word(csm_pkg::CMD_TEXT, 8'h7A, 1'b0);
        queue_word(csm_pkg::CMD_TEXT, 8'h40, 1'b1);
        // Append in the middle of a text abandons it; pattern then outgrows the text
        queue_word(csm_pkg::CMD_TEXT, 8'hFF, 1'b0);
        queue_word(csm_pkg::CMD_APPEND, 8'h5B, 1'b0);
        queue_word(csm_pkg::CMD_TEXT, 8'h60, 1'b1);
        queue_word(csm_pkg::CMD_CLEAR, 8'h00, 1'b0);
        queue_word(csm_pkg::CMD_TEXT, 8'h7B, 1'b1);

        // Pattern overfill and text overrun once each up front
        build_pattern($urandom_range(129, 140), 0);
        build_text($urandom_range(150, 220), 1);
        build_pattern($urandom_range(1, 3), 0);
        build_text($urandom_range(257, 270), 1);

        while (words_queued < 1000 || texts_queued < 60)
        begin
            // Now and then stop offering until the result queue is empty
            if ($urandom_range(0, 19) == 0)
            begin
                queue_word(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'b0, 1);
            end
            k = $urandom_range(0, 99);
            if (k < 75)
            begin
                build_pattern($urandom_range(0, 6), ($urandom_range(0, 3) == 0));
                repeat ($urandom_range(1, 3))
                begin
                    build_text($urandom_range(1, 20), 1);
                end
            end
            else if (k < 77)
            begin
                build_pattern($urandom_range(120, 135), 0);
                build_text($urandom_range(120, 200), 1);
            end
            else if (k < 79)
            begin
                build_pattern($urandom_range(1, 4), 0);
                build_text($urandom_range(250, 270), 1);
            end
            else if (k < 89)
            begin
                // Broken text: left unclosed, then up to two appends (any one drops it) and a closed one
                build_pattern($urandom_range(1, 4), 0);
                build_text($urandom_range(1, 10), 0);
                build_pattern($urandom_range(0, 2), 1);
                build_text($urandom_range(1, 15), 1);
            end
            else
            begin
                build_noise($urandom_range(3, 12));
            end
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: offer queued words, hold each until taken
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            command   <= csm_pkg::CMD_CLEAR;
            data_byte <= 8'h00;
            text_end  <= 1'b0;
            tx_cnt     = 0;
        end
        else
        begin
            take_cmd = cmd_valid && !cmd_stall;
            if (take_cmd)
            begin
                track_matcher(command, data_byte, text_end);
            end
            // A stalled word stays as it is; otherwise pick the next one
            if (take_cmd || !cmd_valid)
            begin
                if (take_cmd && pending_words.size() > 0)
                begin
                    tx_cnt = pending_words[0].gap;
                end
                if (tx_cnt != 0)
                begin
                    tx_cnt--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_words.size() > 0 &&
                         (!pending_words[0].drain || expected_results.size() == 0))
                begin
                    cmd_valid <= 1'b1;
                    command   <= pending_words[0].cmd;
                    data_byte <= pending_words[0].data;
                    text_end  <= pending_words[0].last;
                    void'(pending_words.pop_front());
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: take results, compare against the oldest prediction
    // ---------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            rx_hold    = 0;
        end
        else
        begin
            take_res = res_valid && !res_stall;
            rx_cnt   = rx_hold;
            if (take_res)
            begin
                if (expected_results.size() == 0)
                begin
                    report($sformatf("unexpected result found=%0b pos=%0d trunc=%0b",
                                     found, match_position, truncated));
                end
                else if (found !== expected_results[0].found ||
                         match_position !== expected_results[0].match_position ||
                         truncated !== expected_results[0].truncated)
                begin
                    report($sformatf("result %0d: got %0b/%0d/%0b, want %0b/%0d/%0b",
                                     results_seen, found, match_position, truncated,
                                     expected_results[0].found,
                                     expected_results[0].match_position,
                                     expected_results[0].truncated));
                end
                if (expected_results.size() != 0)
                begin
                    void'(expected_results.pop_front());
                end
                results_seen++;
                if (results_seen % 16 == 0)
                begin
                    rx_fast = ($urandom_range(0, 3) == 0);
                end
                // One long hold lets the result buffer fill and back up the input
                if (results_seen == LONG_HOLD_AT)
                begin
                    rx_cnt = LONG_HOLD_CYCLES;
                end
                else
                begin
                    rx_cnt = rx_fast ? 0 : $urandom_range(0, 14);
                end
            end
            if (rx_cnt != 0)
            begin
                res_stall <= 1'b1;
                rx_hold    = rx_cnt - 1;
            end
            else
            begin
                res_stall <= 1'b0;
                rx_hold    = 0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Sequencing: reset, run the queue dry, drain, verdict
    // ---------------------------------------------------------------------
    initial
    begin
        load_stimulus();
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_words.size() != 0 || cmd_valid)
        begin
            @(posedge clk);
        end
        while (expected_results.size() != 0)
        begin
            @(posedge clk);
        end
        // Allow a stray late result to show up
        repeat (10) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("tb_top OK");
        end
        else
        begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run
    initial
    begin
        #4800000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/csm_pkg.sv
rtl/core/csm_cell.sv
rtl/core/csm_out_skid.sv
rtl/core/case_insensitive_substring_match.sv
rtl/core/csm_checker.sv
tb/tb_top.sv
